// File: src/ast_pkg.sv
`default_nettype none

package ast_pkg;

  localparam int ADDR_W = 32;
  localparam int AGE_W  = 8;
  localparam int OP_W   = 2;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [AGE_W-1:0]  age_t;

  // Item operation codes.
  localparam op_t OP_REGISTER = 2'd0;
  localparam op_t OP_QUERY    = 2'd1;
  localparam op_t OP_TICK     = 2'd2;

  localparam age_t AGE_MAX         = 8'd255;
  localparam age_t AGE_LIMIT_RESET = 8'd5;

  // One table entry as held in the entry memory.
  typedef struct packed {
    logic  valid;
    age_t  age;
    addr_t address;
  } entry_t;

endpackage

`default_nettype wire

// File: src/ast_in_if.sv
`default_nettype none

interface ast_in_if;
  import ast_pkg::*;

  logic  valid;
  logic  ready;
  op_t   op;
  addr_t ip_address;

  modport source (output valid, output op, output ip_address, input ready);
  modport sink (input valid, input op, input ip_address, output ready);
endinterface

`default_nettype wire

// File: src/ast_out_if.sv
`default_nettype none

interface ast_out_if;
  logic valid;
  logic ready;
  logic present;
  logic status;

  modport source (output valid, output present, output status, input ready);
  modport sink (input valid, input present, input status, output ready);
endinterface

`default_nettype wire

// File: src/aging_session_table.sv
// Channel   Dir  Payload                 Handshake
// in_chan   in   op[1:0], ip_address[31:0]  valid/ready
// out_chan  out  present, status         valid/ready
// cfg       in   cfg_wr_data[7:0]        cfg_wr_en, no wait
//
// Every register, query or tick item scans the whole entry memory through its
// single read port, one entry per cycle, before the block is ready again; an
// unused op code skips the scan. After reset a clearing pass writes every
// entry invalid; no item is accepted during that pass. A stalled result
// waits in the output register while the next item is already accepted and
// scanned.
`default_nettype none

module aging_session_table #(
  parameter int ENTRIES = 64
) (
  input  wire              clk,
  input  wire              rst_n,
  ast_in_if.sink           in_chan,
  ast_out_if.source        out_chan,
  input  wire              cfg_wr_en,
  input  wire [7:0]        cfg_wr_data
);
  import ast_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRIES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RESULT
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic             pend_r;
  logic [IDX_W-1:0] pend_idx_r;
  op_t              op_r;
  addr_t            addr_r;
  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic             free_r;
  logic [IDX_W-1:0] free_idx_r;
  age_t             age_limit_r;
  logic             out_valid_r;
  logic             present_r;
  logic             status_r;

  logic             rd_en;
  logic [IDX_W-1:0] rd_idx;
  entry_t           rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  entry_t           wr_data;
  age_t             aged;

  ast_entry_ram #(
    .DEPTH (ENTRIES),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  // Handshake outputs.
  assign in_chan.ready    = (state_r == ST_IDLE);
  assign out_chan.valid   = out_valid_r;
  assign out_chan.present = present_r;
  assign out_chan.status  = status_r;

  // Scan reads walk the memory in index order.
  assign rd_en  = (state_r == ST_SCAN) && (cnt_r != CNT_END);
  assign rd_idx = cnt_r[IDX_W-1:0];

  // Saturating age increment for the entry just read.
  assign aged = (rd_data.age == AGE_MAX) ? rd_data.age : rd_data.age + 8'd1;

  // Write port: clearing pass, tick write-back, or the registration update.
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = cnt_r[IDX_W-1:0];
    wr_data = '0;
    case (state_r)
      ST_CLEAR: begin
        wr_en = 1'b1;
      end
      ST_SCAN: begin
        if (pend_r && (op_r == OP_TICK) && rd_data.valid) begin
          wr_en           = 1'b1;
          wr_idx          = pend_idx_r;
          wr_data.valid   = (aged <= age_limit_r);
          wr_data.age     = aged;
          wr_data.address = rd_data.address;
        end
      end
      ST_UPDATE: begin
        if (op_r == OP_REGISTER && (hit_r || free_r)) begin
          wr_en           = 1'b1;
          wr_idx          = hit_r ? hit_idx_r : free_idx_r;
          wr_data.valid   = 1'b1;
          wr_data.age     = '0;
          wr_data.address = addr_r;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Sequencer, scan bookkeeping and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      age_limit_r <= AGE_LIMIT_RESET;
    end else begin
      if (cfg_wr_en) begin
        age_limit_r <= cfg_wr_data;
      end
      // The output register empties when its item is taken, unless a new
      // result is loaded into it in the same cycle.
      if (out_valid_r && out_chan.ready && state_r != ST_RESULT) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_CLEAR: begin
          if (cnt_r == CNT_LAST) begin
            cnt_r   <= '0;
            state_r <= ST_IDLE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end

        ST_IDLE: begin
          if (in_chan.valid) begin
            op_r   <= in_chan.op;
            addr_r <= in_chan.ip_address;
            hit_r  <= 1'b0;
            free_r <= 1'b0;
            cnt_r  <= '0;
            pend_r <= 1'b0;
            if (in_chan.op inside {OP_REGISTER, OP_QUERY, OP_TICK}) begin
              state_r <= ST_SCAN;
            end else begin
              state_r <= ST_RESULT;
            end
          end
        end

        ST_SCAN: begin
          // Look at the entry read in the previous cycle.
          if (pend_r && op_r != OP_TICK) begin
            if (rd_data.valid && rd_data.address == addr_r && !hit_r) begin
              hit_r     <= 1'b1;
              hit_idx_r <= pend_idx_r;
            end
            if (!rd_data.valid && !free_r) begin
              free_r     <= 1'b1;
              free_idx_r <= pend_idx_r;
            end
          end
          // Issue the next read, or finish once the last one has returned.
          if (cnt_r != CNT_END) begin
            pend_r     <= 1'b1;
            pend_idx_r <= cnt_r[IDX_W-1:0];
            cnt_r      <= cnt_r + 1'b1;
          end else begin
            pend_r <= 1'b0;
            if (!pend_r) begin
              state_r <= ST_UPDATE;
            end
          end
        end

        ST_UPDATE: begin
          state_r <= ST_RESULT;
        end

        ST_RESULT: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            present_r   <= (op_r == OP_REGISTER || op_r == OP_QUERY) && hit_r;
            status_r    <= (op_r == OP_REGISTER) && !hit_r && !free_r;
            state_r     <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_CLEAR;
          cnt_r   <= '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/ast_entry_ram.sv
`default_nettype none

module ast_entry_ram #(
  parameter int DEPTH = 64,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire                   clk,
  input  wire                   wr_en,
  input  wire [IDX_W-1:0]       wr_idx,
  input  ast_pkg::entry_t       wr_data,
  input  wire                   rd_en,
  input  wire [IDX_W-1:0]       rd_idx,
  output ast_pkg::entry_t       rd_data
);
  import ast_pkg::*;

  entry_t mem_r [DEPTH];
  entry_t rd_data_r;

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_idx] <= wr_data;
    end
  end

  // Single read port with registered data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire
